// ===== hdl/ftrk_pkg.sv =====
// shared types and constants for the frame peak tracker
// used by ftrk_unpack and tpc_frame_peak_tracker
package ftrk_pkg;

  localparam int CHIPS    = 4;
  localparam int CHANNELS = 68;
  localparam int PAIRS    = CHIPS * CHANNELS;
  localparam int IDX_W    = $clog2(PAIRS);

  localparam logic [11:0] SAMPLE_TOP = 12'hfff;

  typedef logic [IDX_W-1:0] idx_t;

  // request codes carried on req_type
  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // stored peaks of one chip/channel pair
  typedef struct packed {
    logic [11:0] max_val;
    logic [11:0] min_val;
    logic [8:0]  max_bkt;
    logic [8:0]  min_bkt;
  } pair_t;

  localparam pair_t PAIR_RESET = '{max_val: 12'd0, min_val: SAMPLE_TOP,
                                   max_bkt: 9'd0, min_bkt: 9'd0};

  // decoded beat held between the input and result registers
  typedef struct packed {
    req_e        req;
    logic [1:0]  chip;
    logic [6:0]  chan;
    logic [8:0]  bucket;
    logic [11:0] sample;
    logic        bad;
    idx_t        idx;
    logic        evt_zero;
    logic [47:0] evt_time;
  } item_t;

  // one result beat
  typedef struct packed {
    logic [1:0]  chip_id;
    logic [6:0]  channel_id;
    logic [8:0]  bucket_id;
    logic [11:0] sample_value;
    pair_t       peaks;
    logic [47:0] time_diff;
    logic        bad_channel;
  } res_t;

endpackage

// ===== hdl/ftrk_ram.sv =====
// generic single write port, single read port ram with registered read
// no package dependency
module ftrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ftrk_unpack.sv =====
// input beat decoder: unpacks the byte-swapped sample word or the readback query
// depends on ftrk_pkg
module ftrk_unpack (
  input  logic [1:0]     req_type,
  input  logic [31:0]    raw_word,
  input  logic [31:0]    event_id,
  input  logic [47:0]    event_time,
  input  logic [1:0]     query_chip,
  input  logic [6:0]     query_channel,
  output ftrk_pkg::item_t item
);
  import ftrk_pkg::*;

  req_e        req;
  logic [1:0]  chip;
  logic [6:0]  chan;
  logic [8:0]  flat_idx;

  assign req = req_e'(req_type);

  // pick chip and channel from the sample word or the query
  always_comb begin
    case (req)
      REQ_SAMPLE: begin
        chip = raw_word[7:6];
        chan = {raw_word[5:0], raw_word[15]};
      end
      default: begin
        chip = query_chip;
        chan = query_channel;
      end
    endcase
  end

  assign flat_idx = 9'(chip) * 9'(CHANNELS) + 9'(chan);

  always_comb begin
    item          = '0;
    item.req      = req;
    item.chip     = chip;
    item.chan     = chan;
    item.bad      = (32'(chip) >= CHIPS) || (32'(chan) >= CHANNELS);
    item.idx      = IDX_W'(flat_idx);
    item.evt_zero = (event_id == 32'd0);
    item.evt_time = event_time;
    // bucket and sample only come with a sample word
    if (req == REQ_SAMPLE) begin
      item.bucket = {raw_word[14:8], raw_word[23:22]};
      item.sample = {raw_word[19:16], raw_word[31:24]};
    end
  end

endmodule

// ===== hdl/tpc_frame_peak_tracker.sv =====
// Per-channel min/max peak tracker. Takes one beat per cycle with no bubbles
// while out_ready is high: an accepted beat moves from the input register to
// the result register, and the block keeps accepting while a result waits as
// long as the result register frees in the same cycle. The rate is set by the
// single read-modify-write pass over the 272 x 42-bit peak ram (one read port,
// one write port); back-to-back beats to the same pair are forwarded, not
// stalled. Frame headers clear all pairs at once through per-pair valid bits,
// so there is no clearing pass after reset or after a header.
// depends on ftrk_pkg, ftrk_unpack, ftrk_ram
module tpc_frame_peak_tracker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] raw_word,
  input  logic [31:0] event_id,
  input  logic [47:0] event_time,
  input  logic [1:0]  query_chip,
  input  logic [6:0]  query_channel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  chip_id,
  output logic [6:0]  channel_id,
  output logic [8:0]  bucket_id,
  output logic [11:0] sample_value,
  output logic [11:0] max_sample,
  output logic [11:0] min_sample,
  output logic [8:0]  max_bucket,
  output logic [8:0]  min_bucket,
  output logic [47:0] time_diff,
  output logic        bad_channel
);
  import ftrk_pkg::*;

  item_t            dec;
  item_t            s1;
  logic             s1_valid;
  logic             s1_fire;
  logic             s1_write;
  logic             in_fire;
  logic [PAIRS-1:0] valid_bits;
  logic [47:0]      prev_time;
  logic [47:0]      last_diff;
  logic [47:0]      diff_next;
  logic             bypass_hit;
  pair_t            bypass;
  pair_t            rdata;
  pair_t            cur;
  pair_t            upd;
  res_t             res_next;
  res_t             res;

  // decode the incoming beat
  ftrk_unpack u_unpack (
    .req_type      (req_type),
    .raw_word      (raw_word),
    .event_id      (event_id),
    .event_time    (event_time),
    .query_chip    (query_chip),
    .query_channel (query_channel),
    .item          (dec)
  );

  // handshake
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign s1_write = s1_fire && (s1.req == REQ_SAMPLE) && !s1.bad;

  // peak storage, read at accept, written when a good sample leaves stage one
  ftrk_ram #(
    .WIDTH ($bits(pair_t)),
    .DEPTH (PAIRS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_write),
    .waddr (s1.idx),
    .wdata (upd),
    .re    (in_fire),
    .raddr (dec.idx),
    .rdata (rdata)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= dec;
    end
  end

  // forward a write that lands on the same edge as the next read
  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_hit <= 1'b0;
    end else if (in_fire) begin
      bypass_hit <= s1_write && (s1.idx == dec.idx);
    end else if (s1_fire) begin
      bypass_hit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bypass <= upd;
    end
  end

  // current pair and its update
  always_comb begin
    if (valid_bits[s1.idx]) begin
      cur = bypass_hit ? bypass : rdata;
    end else begin
      cur = PAIR_RESET;
    end
    upd = cur;
    if (s1.sample > cur.max_val) begin
      upd.max_val = s1.sample;
      upd.max_bkt = s1.bucket;
    end
    if (s1.sample < cur.min_val) begin
      upd.min_val = s1.sample;
      upd.min_bkt = s1.bucket;
    end
  end

  // event time difference for a header
  assign diff_next = s1.evt_zero ? 48'd0 : (s1.evt_time - prev_time);

  // result beat
  always_comb begin
    res_next = '0;
    case (s1.req)
      REQ_HEADER: begin
        res_next.time_diff = diff_next;
      end
      REQ_SAMPLE, REQ_READ: begin
        res_next.chip_id      = s1.chip;
        res_next.channel_id   = s1.chan;
        res_next.bucket_id    = s1.bucket;
        res_next.sample_value = s1.sample;
        res_next.time_diff    = last_diff;
        res_next.bad_channel  = s1.bad;
        if (!s1.bad) begin
          res_next.peaks = (s1.req == REQ_SAMPLE) ? upd : cur;
        end
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // valid bits and event time state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      prev_time  <= '0;
      last_diff  <= '0;
    end else if (s1_fire && (s1.req == REQ_HEADER)) begin
      valid_bits <= '0;
      prev_time  <= s1.evt_time;
      last_diff  <= diff_next;
    end else if (s1_write) begin
      valid_bits[s1.idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res <= res_next;
    end
  end

  assign chip_id      = res.chip_id;
  assign channel_id   = res.channel_id;
  assign bucket_id    = res.bucket_id;
  assign sample_value = res.sample_value;
  assign max_sample   = res.peaks.max_val;
  assign min_sample   = res.peaks.min_val;
  assign max_bucket   = res.peaks.max_bkt;
  assign min_bucket   = res.peaks.min_bkt;
  assign time_diff    = res.time_diff;
  assign bad_channel  = res.bad_channel;

`ifndef NO_ASSERTIONS
  // a header leaves every pair invalid
  a_header_clears: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (s1.req == REQ_HEADER) |=> valid_bits == '0)
    else $error("valid bits not cleared by header");

  // a good sample marks its pair valid
  a_sample_marks: assert property (@(posedge clk) disable iff (rst)
    s1_write |=> valid_bits[$past(s1.idx)])
    else $error("pair not marked valid after sample");

  // forwarding only serves a beat sitting in stage one
  a_bypass_owner: assert property (@(posedge clk) disable iff (rst)
    bypass_hit |-> s1_valid)
    else $error("bypass flagged with stage one empty");

  // a bad pair never reports peaks
  a_bad_no_peaks: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_channel |-> max_sample == 12'd0 && min_sample == 12'd0 &&
                                 max_bucket == 9'd0 && min_bucket == 9'd0)
    else $error("peaks reported for bad channel");
`endif

endmodule
